@@ rtl/trie_insert_engine_unit_macros.svh @@
// ---------------------------------------------------------------------------
// trie_insert_engine_unit assertion macros
// Concurrent check wrappers, empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef TRIE_INSERT_ENGINE_UNIT_MACROS_SVH
`define TRIE_INSERT_ENGINE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define TIE_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tie check failed");
`define TIE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tie check failed");
`else
`define TIE_ASSERT_SAME(label, clk, rst, ante, cons)
`define TIE_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ rtl/tie_pkg.sv @@
// ---------------------------------------------------------------------------
// tie_pkg
// Shared constants and controller/datapath interface types.
// ---------------------------------------------------------------------------
`default_nettype none
package tie_pkg;
   localparam int DEF_MAX_NODES   = 256;
   localparam int DEF_SYMBOL_BITS = 8;
   localparam int SYMBOL_W        = 8;
   localparam int NODE_W          = 8;
   localparam int RSP_DATA_W      = 3 * NODE_W;

   typedef struct packed {
      logic clear_en;
      logic accept;
      logic commit;
   } tie_cmd_type;

   typedef struct packed {
      logic clear_last;
   } tie_status_type;
endpackage
`default_nettype wire

@@ rtl/trie_insert_engine_unit.sv @@
// ---------------------------------------------------------------------------
// trie_insert_engine_unit
// Streaming trie builder: one pattern symbol in, one edge report out.
// ---------------------------------------------------------------------------
// Usage:
//   req_* carries one symbol per request; req_tlast marks a pattern's end.
//   rsp_* returns one report per request: reached node, parent node and
//   edge symbol in tdata, new-edge and overflow flags in tuser.
//   Each request passes through accept and child-table read, then the
//   commit cycle that may write a new edge and loads the output register.
//   The single-port child table and the walk position, which the next symbol
//   needs, hold a new request back until the previous one has committed.
//   After reset the child table is cleared one entry per cycle, all
//   MAX_NODES << SYMBOL_BITS entries (65536 by default), with req_tready low.
//   A stalled rsp_tready holds the report; one further request is accepted
//   and waits in the commit cycle until the output register frees up.
//   Reset returns the walk to the root with only the root allocated.
// ---------------------------------------------------------------------------
`default_nettype none
`include "trie_insert_engine_unit_macros.svh"
module trie_insert_engine_unit
   import tie_pkg::*;
#(
   parameter int MAX_NODES   = DEF_MAX_NODES,
   parameter int SYMBOL_BITS = DEF_SYMBOL_BITS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [SYMBOL_W-1:0]   req_tdata,  // [7:0] symbol
   input  wire logic                  req_tlast,  // pattern_last
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,  // node_index, parent_index, edge_symbol
   output logic [1:0]                 rsp_tuser   // new_edge, overflow
);
   tie_cmd_type    cmd;
   tie_status_type status;

   tie_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   tie_datapath #(
      .MAX_NODES   (MAX_NODES),
      .SYMBOL_BITS (SYMBOL_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_symbol (req_tdata),
      .req_last   (req_tlast),
      .rsp_data   (rsp_tdata),
      .rsp_flags  (rsp_tuser)
   );

   `TIE_ASSERT_SAME(a_flags_excl, clock, reset, rsp_tvalid, !(rsp_tuser[0] && rsp_tuser[1]))
   `TIE_ASSERT_SAME(a_ovf_stays, clock, reset, rsp_tvalid && rsp_tuser[1], rsp_tdata[7:0] == rsp_tdata[15:8])
   `TIE_ASSERT_NEXT(a_one_in_flight, clock, reset, req_tvalid && req_tready, !req_tready)
endmodule
`default_nettype wire

@@ rtl/tie_ctrl.sv @@
// ---------------------------------------------------------------------------
// tie_ctrl
// Sequencer: table clear after reset, lookup, commit into the output register.
// ---------------------------------------------------------------------------
`default_nettype none
module tie_ctrl
   import tie_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_tvalid,
   output logic          req_tready,
   output logic          rsp_tvalid,
   input  wire logic     rsp_tready,
   input  wire tie_status_type status,
   output tie_cmd_type   cmd
);
   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free     = !rsp_valid_ff || rsp_tready;
   assign req_tready   = (state_ff == ST_IDLE);
   assign rsp_tvalid   = rsp_valid_ff;
   assign cmd.clear_en = (state_ff == ST_CLEAR);
   assign cmd.accept   = (state_ff == ST_IDLE) && req_tvalid;
   assign cmd.commit   = (state_ff == ST_LOOKUP) && out_free;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         ST_CLEAR: begin
            if (status.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_LOOKUP;
         end
         ST_LOOKUP: begin
            if (out_free) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule
`default_nettype wire

@@ rtl/tie_datapath.sv @@
// ---------------------------------------------------------------------------
// tie_datapath
// Child table memory, walk position, node allocator and result register.
// ---------------------------------------------------------------------------
`default_nettype none
module tie_datapath
   import tie_pkg::*;
#(
   parameter int MAX_NODES   = DEF_MAX_NODES,
   parameter int SYMBOL_BITS = DEF_SYMBOL_BITS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire tie_cmd_type           cmd,
   output tie_status_type             status,
   input  wire logic [SYMBOL_W-1:0]   req_symbol,
   input  wire logic                  req_last,
   output logic [RSP_DATA_W-1:0]      rsp_data,
   output logic [1:0]                 rsp_flags
);
   localparam int NODE_BITS = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int ADDR_BITS = NODE_BITS + SYMBOL_BITS;
   localparam int DEPTH     = MAX_NODES << SYMBOL_BITS;

   // entry: valid bit above child index
   logic [NODE_BITS:0]     table_mem [DEPTH];
   logic [NODE_BITS:0]     rd_ff;
   logic [ADDR_BITS-1:0]   clr_cnt_ff;
   logic [SYMBOL_BITS-1:0] sym_ff;
   logic                   last_ff;
   logic [NODE_BITS-1:0]   cur_ff, cur_in;
   logic [NODE_BITS:0]     used_ff, used_in;
   logic                   drop_ff, drop_in;
   logic [NODE_W-1:0]      node_out_ff, parent_out_ff, sym_out_ff;
   logic                   fresh_out_ff, ovf_out_ff;

   logic [NODE_BITS-1:0]   node;
   logic                   fresh, ovf, full;
   logic [NODE_BITS+7:0]   node_pad, parent_pad;
   logic [SYMBOL_BITS+7:0] sym_pad;

   assign status.clear_last = (clr_cnt_ff == ADDR_BITS'(DEPTH - 1));
   assign full = (used_ff == (NODE_BITS + 1)'(MAX_NODES));

   always_comb begin
      node  = cur_ff;
      fresh = 1'b0;
      ovf   = 1'b0;
      if (drop_ff) begin
         ovf = 1'b1;
      end else if (rd_ff[NODE_BITS]) begin
         node = rd_ff[NODE_BITS-1:0];
      end else if (!full) begin
         node  = used_ff[NODE_BITS-1:0];
         fresh = 1'b1;
      end else begin
         ovf = 1'b1;
      end
      used_in = fresh ? used_ff + 1'b1 : used_ff;
      cur_in  = last_ff ? '0 : node;
      drop_in = !last_ff && (drop_ff || ovf);
   end

   assign node_pad   = {8'd0, node};
   assign parent_pad = {8'd0, cur_ff};
   assign sym_pad    = {8'd0, sym_ff};

   always_ff @(posedge clock) begin
      if (cmd.clear_en) begin
         table_mem[clr_cnt_ff] <= '0;
      end else if (cmd.commit && fresh) begin
         table_mem[{cur_ff, sym_ff}] <= {1'b1, used_ff[NODE_BITS-1:0]};
      end
      if (cmd.accept) begin
         rd_ff   <= table_mem[{cur_ff, req_symbol[SYMBOL_BITS-1:0]}];
         sym_ff  <= req_symbol[SYMBOL_BITS-1:0];
         last_ff <= req_last;
      end
      if (cmd.commit) begin
         node_out_ff   <= node_pad[7:0];
         parent_out_ff <= parent_pad[7:0];
         sym_out_ff    <= sym_pad[7:0];
         fresh_out_ff  <= fresh;
         ovf_out_ff    <= ovf;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
         cur_ff     <= '0;
         used_ff    <= (NODE_BITS + 1)'(1);
         drop_ff    <= 1'b0;
      end else begin
         if (cmd.clear_en && !status.clear_last) clr_cnt_ff <= clr_cnt_ff + 1'b1;
         if (cmd.commit) begin
            cur_ff  <= cur_in;
            used_ff <= used_in;
            drop_ff <= drop_in;
         end
      end
   end

   assign rsp_data  = {sym_out_ff, parent_out_ff, node_out_ff};
   assign rsp_flags = {ovf_out_ff, fresh_out_ff};
endmodule
`default_nettype wire

@@ tb/tb.sv @@
// ---------------------------------------------------------------------------
// tb - trie_insert_engine_unit testbench
// Streams patterns one symbol per request and checks every edge report
// against a software trie: duplicate and prefix patterns, extensions, fresh
// and noisy patterns, node store exhaustion and dropped-pattern handling,
// with bursty request traffic and random response backpressure.
// ---------------------------------------------------------------------------
module tb;
   import tie_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TRIE_NODES   = DEF_MAX_NODES;
   localparam int SYM_MASK     = (1 << DEF_SYMBOL_BITS) - 1;
   localparam int RUN_ITEMS    = 1800;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int LIB_DEPTH    = 8192;
   localparam int LIB_PATTERNS = 500;
   localparam int PAT_MAX      = 16;
   localparam bit [7:0] DOLLAR = 8'h24;

   typedef struct packed {
      bit [7:0] node;
      bit [7:0] parent;
      bit [7:0] sym;
      bit       fresh;
      bit       ovf;
   } edge_report_type;

   class trie_scoreboard;
      bit [7:0]        child_of [bit [15:0]];
      bit              end_mark [0:TRIE_NODES-1];
      int              nodes_used;
      bit [7:0]        walk_node;
      bit              dropped;
      edge_report_type expected_reports [$];
      int              errors, checked, patterns, new_edges, overflows;

      function new();
         nodes_used = 1;
         walk_node  = 0;
         dropped    = 0;
         foreach (end_mark[i]) end_mark[i] = 0;
      endfunction

      function int pending();
         return expected_reports.size();
      endfunction

      function void note_request(bit [7:0] symbol, bit last);
         edge_report_type r;
         bit [15:0] key;
         r.parent = walk_node;
         r.node   = walk_node;
         r.sym    = symbol & SYM_MASK[7:0];
         r.fresh  = 0;
         r.ovf    = 0;
         key      = {walk_node, r.sym};
         if (dropped) begin
            r.ovf = 1;
         end else if (child_of.exists(key)) begin
            r.node = child_of[key];
         end else if (nodes_used < TRIE_NODES) begin
            r.node        = nodes_used[7:0];
            child_of[key] = r.node;
            nodes_used++;
            r.fresh = 1;
            new_edges++;
         end else begin
            r.ovf   = 1;
            dropped = 1;
         end
         if (r.ovf) overflows++;
         if (last) begin
            if (!r.ovf) end_mark[r.node] = 1;
            walk_node = 0;
            dropped   = 0;
            patterns++;
         end else begin
            walk_node = r.node;
         end
         expected_reports = {expected_reports, r};
      endfunction

      function void compare_field(string name, int want, int got);
         if (want != got) begin
            $display("%0t ERROR: %s expected %0d actual %0d", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_report(bit [RSP_DATA_W-1:0] tdata, bit [1:0] tuser);
         edge_report_type want;
         if (expected_reports.size() == 0) begin
            $display("%0t ERROR: unexpected report expected none actual tdata=%h tuser=%b",
                     $time, tdata, tuser);
            errors++;
            return;
         end
         want = expected_reports.pop_front();
         checked++;
         compare_field("node_index", int'(want.node), int'(tdata[7:0]));
         compare_field("parent_index", int'(want.parent), int'(tdata[15:8]));
         compare_field("edge_symbol", int'(want.sym), int'(tdata[23:16]));
         compare_field("new_edge", int'(want.fresh), int'(tuser[0]));
         compare_field("overflow", int'(want.ovf), int'(tuser[1]));
      endfunction
   endclass

   logic                  clock      = 0;
   logic                  reset      = 1;
   logic                  req_tvalid = 0;
   logic                  req_tready;
   logic [SYMBOL_W-1:0]   req_tdata  = '0;
   logic                  req_tlast  = 0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [1:0]            rsp_tuser;

   trie_scoreboard sb = new();

   int       cycles     = 0;
   int       items_sent = 0;
   int       burst_left = 0;
   int       rx_mode    = 0;
   int       rx_span    = 0;
   int       rx_tick    = 0;
   bit [7:0] pat [0:PAT_MAX-1];
   int       pat_len;
   bit [7:0] lib_sym [0:LIB_DEPTH-1];
   int       lib_start [$];
   int       lib_len [$];
   int       lib_fill   = 0;

   always #6 clock = ~clock;

   trie_insert_engine_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t ERROR: timeout after %0d cycles", $time, cycles);
         $display("Test completed with failures");
         $finish;
      end
   end

   // response side: stall pattern switches between modes every span
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_report(rsp_tdata, rsp_tuser);
      rx_tick <= rx_tick + 1;
      if (rx_span == 0) begin
         rx_mode <= $urandom_range(0, 3);
         rx_span <= $urandom_range(10, 40);
      end else begin
         rx_span <= rx_span - 1;
      end
      case (rx_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= 1'($urandom_range(0, 1));
         2: rsp_tready <= (rx_tick % 4 == 0);
         default: rsp_tready <= (rx_span == 0);
      endcase
   end

   task automatic pace();
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                                : $urandom_range(1, 12);
         gap = $urandom_range(0, 5);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
   endtask

   task automatic send_symbol(bit [7:0] symbol, bit last);
      pace();
      req_tvalid <= 1'b1;
      req_tdata  <= symbol;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      sb.note_request(symbol, last);
      items_sent++;
   endtask

   task automatic send_pattern();
      for (int i = 0; i < pat_len; i++) send_symbol(pat[i], i == pat_len - 1);
      if (lib_start.size() < LIB_PATTERNS && lib_fill + pat_len <= LIB_DEPTH) begin
         lib_start = {lib_start, lib_fill};
         lib_len   = {lib_len, pat_len};
         for (int i = 0; i < pat_len; i++) lib_sym[lib_fill + i] = pat[i];
         lib_fill += pat_len;
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   function automatic bit [7:0] rand_symbol(bit wide);
      if (wide) return 8'($urandom_range(0, 255));
      case ($urandom_range(0, 4))
         0: return "a";
         1: return "b";
         2: return "c";
         3: return "d";
         default: return DOLLAR;
      endcase
   endfunction

   task automatic directed(input bit [7:0] a, b, c, d, input int n);
      pat[0] = a; pat[1] = b; pat[2] = c; pat[3] = d;
      pat_len = n;
      send_pattern();
   endtask

   initial begin
      int choice, pick, base, extra;
      repeat (8) @(posedge clock);
      reset <= 0;

      directed(8'h00, 8'h00, 8'h00, 8'h00, 1);
      directed(8'hFF, 8'hAA, 8'h55, 8'h00, 3);
      directed(8'hFF, 8'hAA, 8'h55, 8'h00, 3);
      directed(8'hFF, 8'hAA, 8'h00, 8'h00, 2);
      directed(8'hFF, 8'hAA, 8'h55, DOLLAR, 4);
      directed(8'h00, 8'h00, 8'h00, 8'h00, 2);
      directed(DOLLAR, 8'h00, 8'h00, 8'h00, 1);
      directed(8'h80, 8'h01, 8'h00, 8'h00, 2);
      directed(8'h7F, 8'h00, 8'h00, 8'h00, 1);
      drain();

      while (items_sent < RUN_ITEMS) begin
         choice = (lib_start.size() == 0) ? 80 : $urandom_range(0, 99);
         pick   = (lib_start.size() == 0) ? 0 : $urandom_range(0, lib_start.size() - 1);
         if (choice < 70) begin
            base    = lib_start[pick];
            pat_len = lib_len[pick];
            for (int i = 0; i < pat_len; i++) pat[i] = lib_sym[base + i];
            if (choice >= 35 && choice < 50) begin
               pat_len = $urandom_range(1, pat_len);
            end else if (choice >= 50) begin
               extra = $urandom_range(1, 4);
               if (pat_len + extra > PAT_MAX) extra = PAT_MAX - pat_len;
               for (int i = 0; i < extra; i++) pat[pat_len + i] = rand_symbol(0);
               pat_len += extra;
            end
         end else if (choice < 90) begin
            pat_len = $urandom_range(1, 8);
            for (int i = 0; i < pat_len; i++)
               pat[i] = rand_symbol($urandom_range(0, 7) == 0);
         end else begin
            pat_len = $urandom_range(1, 12);
            for (int i = 0; i < pat_len; i++) pat[i] = rand_symbol(1);
         end
         send_pattern();
         if ($urandom_range(0, 199) == 0) drain();
      end

      drain();
      repeat (10) @(posedge clock);
      $display("Run: %0d requests in %0d patterns, %0d reports checked.",
               items_sent, sb.patterns, sb.checked);
      $display("Trie: %0d nodes allocated, %0d requests hit a full store or dropped pattern.",
               sb.nodes_used, sb.overflows);
      if (sb.errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule

@@ files.f @@
+incdir+rtl
rtl/tie_pkg.sv
rtl/tie_ctrl.sv
rtl/tie_datapath.sv
rtl/trie_insert_engine_unit.sv
tb/tb.sv
